[rtl/core/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante.
`define BPFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BPFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BPFA_ASSERT_IMP(lbl, ante, cons, msg)
`define BPFA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/bpfa_pkg.sv]
// Types and constants of the page frame allocator.
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] REG_KERNEL_END   = 2'd0;
  localparam logic [1:0] REG_PAGING_START = 2'd1;
  localparam logic [1:0] REG_PAGING_END   = 2'd2;

  localparam logic [31:0] KERNEL_END_RST = 32'h0010_0000;

  // Frame numbers are 21 bits: a rounded-up 32-bit page address can reach 2^20.
  localparam int unsigned FRAME_W = 21;
  localparam logic [FRAME_W-1:0] FREE_LO_FRAME = 21'd256;   // 1 MiB
  localparam logic [FRAME_W-1:0] FREE_HI_FRAME = 21'd1024;  // 4 MiB

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] free_address;
  } bpfa_cmd_t;

  typedef struct packed {
    logic [21:0] frame_address;
    logic        out_of_memory;
  } bpfa_result_t;

  // Exclusion bounds as frame numbers, taken at the start of an init.
  typedef struct packed {
    logic [FRAME_W-1:0] kern_lim;
    logic [FRAME_W-1:0] pg_lo;
    logic [FRAME_W-1:0] pg_hi;
  } bpfa_bounds_t;

endpackage

[rtl/core/bpfa_bitmap_ram.sv]
// Used/free bitmap storage, one write port and one registered read port.
`timescale 1ns / 1ps

module bpfa_bitmap_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bpfa_frame_chk.sv]
// Frame classifier: decides whether init releases a given frame.
`timescale 1ns / 1ps

module bpfa_frame_chk
  import bpfa_pkg::*;
(
  input  logic [FRAME_W-1:0] frame_i,
  input  bpfa_bounds_t       bounds_i,
  output logic               free_o
);

  logic in_space;
  logic in_kernel;
  logic in_paging;

  always_comb begin
    in_space  = (frame_i >= FREE_LO_FRAME) && (frame_i < FREE_HI_FRAME);
    // Kernel range starts at 1 MiB, already covered by the lower space bound.
    in_kernel = frame_i < bounds_i.kern_lim;
    in_paging = (frame_i >= bounds_i.pg_lo) && (frame_i < bounds_i.pg_hi);
    free_o    = in_space && !in_kernel && !in_paging;
  end

endmodule

[rtl/core/bitmap_page_frame_allocator.sv]
// Top level of the bitmap page frame allocator.
//
// Usage: drive cmd_i and raise start_i; the beat is taken at a rising edge
// with start_i high and busy_o low. Every command gives exactly one result
// beat on result_o, marked by done_o for one cycle; the receiver cannot
// stall it, so sample it when done_o is high.
// Commands: init rebuilds the bitmap (all used, then frames 1..4 MiB freed
// except the kernel image and paging tables), alloc takes the lowest free
// frame and returns its byte address (out_of_memory with address 0 when none
// is left), free releases the frame holding free_address. Unknown opcodes
// and out-of-range frees complete the cycle after acceptance with 0, 0.
// Steps: free reads the bitmap byte and then writes it back; alloc scans
// from byte 0, one bitmap byte read per cycle through the single read port,
// until a byte with a free frame; init walks all frames, one frame per cycle
// through the shared frame classifier. One command is in flight at a time.
// Configuration: cfg_we_i writes register cfg_idx_i at once; write only
// while busy_o is low and no result is pending.
// Reset: busy_o stays high for BITMAP_BYTES cycles while a clearing pass
// marks every frame used; commands are taken after that.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int unsigned BITMAP_BYTES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  bpfa_cmd_t    cmd_i,
  output logic         busy_o,
  output logic         done_o,
  output bpfa_result_t result_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITMAP_BYTES - 1);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_INIT    = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_FREE_RD = 3'd4;
  localparam logic [2:0] S_FREE_WR = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] data_idx_q;
  logic [2:0]       bit_q, bit_d;
  logic [6:0]       acc_q, acc_d;
  logic             pend_q, pend_d;
  bpfa_bounds_t     bounds_q, bounds_d;
  logic             done_q, done_d;
  bpfa_result_t     result_q, result_d;

  logic [31:0] kernel_end_q;
  logic [31:0] paging_start_q;
  logic [31:0] paging_end_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  logic             frame_free;
  logic [2:0]       hit_bit;
  logic [FRAME_W-1:0] hit_frame;
  logic [19:0]      kern_pages;

  logic             oom_beat;
  logic             alloc_take;

  // Lowest clear bit of a byte that is not all ones.
  function automatic logic [2:0] low_zero(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!v[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q   <= KERNEL_END_RST;
      paging_start_q <= '0;
      paging_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KERNEL_END:   kernel_end_q   <= cfg_wdata_i;
        REG_PAGING_START: paging_start_q <= cfg_wdata_i;
        REG_PAGING_END:   paging_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bpfa_bitmap_ram #(
    .Depth (BITMAP_BYTES),
    .AddrW (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Shared classifier, walked over one frame per cycle during init.
  bpfa_frame_chk u_chk (
    .frame_i  (FRAME_W'({idx_q, bit_q})),
    .bounds_i (bounds_q),
    .free_o   (frame_free)
  );

  assign hit_bit    = low_zero(ram_rdata);
  assign hit_frame  = FRAME_W'({data_idx_q, hit_bit});
  // Kernel end rounded up to a page, wrapping in 20 bits as a page count.
  assign kern_pages = kernel_end_q[31:12] + 20'(|kernel_end_q[11:0]);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    acc_d     = acc_q;
    pend_d    = pend_q;
    bounds_d  = bounds_q;
    done_d    = 1'b0;
    result_d  = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = 8'hFF;

    case (state_q)
      S_CLEAR: begin
        // Mark every frame used after reset, one byte a cycle.
        ram_we = 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          case (cmd_i.opcode)
            OP_INIT: begin
              bounds_d.kern_lim = {1'b0, kern_pages};
              bounds_d.pg_lo    = {1'b0, paging_start_q[31:12]}
                                  + FRAME_W'(|paging_start_q[11:0]);
              bounds_d.pg_hi    = {1'b0, paging_end_q[31:12]}
                                  + FRAME_W'(|paging_end_q[11:0]);
              idx_d   = '0;
              bit_d   = '0;
              state_d = S_INIT;
            end
            OP_ALLOC: begin
              idx_d   = '0;
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
            OP_FREE: begin
              if ({1'b0, cmd_i.free_address[31:15]} < 18'(BITMAP_BYTES)) begin
                idx_d   = cmd_i.free_address[15 +: IDX_W];
                bit_d   = cmd_i.free_address[14:12];
                state_d = S_FREE_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_INIT: begin
        // Collect seven frame bits, write the byte with the eighth.
        if (bit_q == 3'd7) begin
          ram_we    = 1'b1;
          ram_wdata = {!frame_free, acc_q};
          bit_d     = '0;
          if (idx_q == LAST_IDX) begin
            idx_d   = '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          acc_d = {!frame_free, acc_q[6:1]};
          bit_d = bit_q + 3'd1;
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; hold at the last byte until it is checked.
        pend_d = 1'b1;
        if (idx_q != LAST_IDX) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q) begin
          if (ram_rdata != 8'hFF) begin
            ram_we                 = 1'b1;
            ram_waddr              = data_idx_q;
            ram_wdata              = ram_rdata | (8'b1 << hit_bit);
            done_d                 = 1'b1;
            result_d.frame_address = {hit_frame[9:0], 12'h000};
            state_d                = S_IDLE;
          end else if (data_idx_q == LAST_IDX) begin
            done_d                 = 1'b1;
            result_d.out_of_memory = 1'b1;
            state_d                = S_IDLE;
          end
        end
      end

      S_FREE_RD: begin
        state_d = S_FREE_WR;
      end

      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(8'b1 << bit_q);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      bit_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      bit_q   <= bit_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    bounds_q   <= bounds_d;
    data_idx_q <= idx_q;
    result_q   <= result_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  assign oom_beat   = done_o && result_o.out_of_memory;
  assign alloc_take = start_i && !busy_o && (cmd_i.opcode == OP_ALLOC);

  `BPFA_ASSERT_IMP(a_oom_addr_zero, oom_beat, result_o.frame_address == '0, "oom with address")
  `BPFA_ASSERT_NXT(a_alloc_goes_busy, alloc_take, busy_o, "alloc accepted without scan")
  `BPFA_ASSERT_IMP(a_idle_no_write, state_q == S_IDLE, !ram_we, "bitmap written while idle")

endmodule
